// ----- rtl/decimal_lsd_radix_sorter_macros.svh -----
// Assertion macros for the decimal LSD radix sorter.
`ifndef DECIMAL_LSD_RADIX_SORTER_MACROS_SVH
`define DECIMAL_LSD_RADIX_SORTER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DLRS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DLRS_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DLRS_ASSERT(label, clk, rst, prop, msg)
`define DLRS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- rtl/dlrs_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dlrs_pkg
// Types and constants shared by the decimal LSD radix sorter.
// ---------------------------------------------------------------------------
package dlrs_pkg;
   localparam int MAX_ITEMS = 64;
   localparam int IDX_W = $clog2(MAX_ITEMS);
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int VAL_W = 31;
   localparam int ENT_W = 2 * VAL_W;
   localparam int RADIX = 10;
   localparam int QDEPTH = 2;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic             last_in;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0] sorted_value;
      logic             last_out;
      logic             overflow;
   } rsp_type;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic             store;
      logic             close;
   } cmd_type;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic [VAL_W-1:0] quo;
   } entry_type;

   typedef enum logic [3:0] {
      ST_LOAD, ST_CLEAR, ST_COUNT, ST_PREFIX, ST_PLACE_RD, ST_PLACE_WR,
      ST_COPY_RD, ST_COPY_WR, ST_NEXT, ST_OUT_RD, ST_OUT_WR
   } state_type;
endpackage

// ----- rtl/dlrs_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dlrs_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module dlrs_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ----- rtl/dlrs_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dlrs_front
// Accepts input words, classifies them as stored or dropped, and queues
// commands for the sorting engine.
// ---------------------------------------------------------------------------
`include "decimal_lsd_radix_sorter_macros.svh"
module dlrs_front import dlrs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    cmd_valid,
   input  logic    cmd_ready,
   output cmd_type cmd_data
);
   logic [CNT_W-1:0] count_ff, count_in;
   cmd_type          q_ff [QDEPTH];
   cmd_type          q_in [QDEPTH];
   logic [1:0]       fill_ff, fill_in;
   logic             push, pop;
   cmd_type          cmd_new;

   assign req_ready = (fill_ff != 2'(QDEPTH));
   assign push = req_valid && req_ready;
   assign pop = cmd_valid && cmd_ready;
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd_data = q_ff[0];

   always_comb begin
      cmd_new.value = req_data.value;
      cmd_new.store = (count_ff < CNT_W'(MAX_ITEMS));
      cmd_new.close = req_data.last_in;
      count_in = count_ff;
      if (push) begin
         if (req_data.last_in) begin
            count_in = '0;
         end else if (cmd_new.store) begin
            count_in = count_ff + 1'b1;
         end
      end
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop};
      q_in = q_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
      end
      if (push) begin
         if (fill_ff == 2'd0 || (pop && fill_ff == 2'd1)) begin
            q_in[0] = cmd_new;
         end else begin
            q_in[1] = cmd_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fill_ff <= '0;
      end else begin
         count_ff <= count_in;
         fill_ff <= fill_in;
      end
      q_ff <= q_in;
   end

   `DLRS_ASSERT(a_fill_bound, clock, reset, fill_ff <= 2'(QDEPTH), "queue overfilled")
   `DLRS_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(MAX_ITEMS), "count overran")
   `DLRS_ASSERT(a_close_clears, clock, reset, push && req_data.last_in |=> count_ff == '0,
      "count not cleared at set end")
endmodule

// ----- rtl/dlrs_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dlrs_back
// Stores values, runs the counting-sort digit passes and emits the result.
// ---------------------------------------------------------------------------
`include "decimal_lsd_radix_sorter_macros.svh"
module dlrs_back import dlrs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [VAL_W-1:0] max_ff, max_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] cnt_ff [RADIX];
   logic [CNT_W-1:0] cnt_in [RADIX];
   logic [VAL_W-1:0] div_ff, div_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff, out_in;

   logic             p_we, s_we;
   logic [IDX_W-1:0] p_wa, p_ra, s_wa, s_ra;
   entry_type        p_wd, p_rd, s_rd;

   dlrs_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ITEMS)) u_primary (
      .clock(clock), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
      .rd_addr(p_ra), .rd_data(p_rd));
   dlrs_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ITEMS)) u_scratch (
      .clock(clock), .wr_en(s_we), .wr_addr(s_wa), .wr_data(p_rd),
      .rd_addr(s_ra), .rd_data(s_rd));

   // Each entry carries its value and the value divided by the current place,
   // so the digit of a pass is the low decimal digit of the stored quotient.
   // The quotient is divided by ten as entries are copied back after a pass.
   function automatic logic [VAL_W-1:0] div_ten(input logic [VAL_W-1:0] x);
      logic [63:0] p;
      p = 64'(x) * 64'd3435973837;
      return VAL_W'(p >> 35);
   endfunction

   function automatic logic [3:0] mod_ten(input logic [VAL_W-1:0] x);
      logic [VAL_W-1:0] q;
      q = div_ten(x);
      return 4'(x - VAL_W'(q * VAL_W'(10)));
   endfunction

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;

   always_comb begin
      logic [3:0] pd;
      state_in = state_ff;
      n_in = n_ff;
      i_in = i_ff;
      max_in = max_ff;
      ovf_in = ovf_ff;
      cnt_in = cnt_ff;
      div_in = div_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in = out_ff;
      cmd_ready = 1'b0;
      p_we = 1'b0;
      s_we = 1'b0;
      p_wa = i_ff[IDX_W-1:0];
      p_wd.value = cmd_data.value;
      p_wd.quo = cmd_data.value;
      p_ra = i_ff[IDX_W-1:0];
      s_wa = '0;
      s_ra = i_ff[IDX_W-1:0];
      pd = '0;
      case (state_ff)
         ST_LOAD: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               if (cmd_data.store) begin
                  p_we = 1'b1;
                  p_wa = n_ff[IDX_W-1:0];
                  n_in = n_ff + 1'b1;
                  if (cmd_data.value > max_ff) max_in = cmd_data.value;
               end else begin
                  ovf_in = 1'b1;
               end
               if (cmd_data.close) begin
                  div_in = cmd_data.store && cmd_data.value > max_ff
                           ? cmd_data.value : max_ff;
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_CLEAR: begin
            for (int k = 0; k < RADIX; k++) cnt_in[k] = '0;
            i_in = '0;
            if (div_ff == '0) state_in = ST_OUT_RD;
            else state_in = ST_COUNT;
         end
         ST_COUNT: begin
            // read issued at i, data arrives next cycle; i_ff runs one ahead
            p_ra = i_ff[IDX_W-1:0];
            if (i_ff != '0) begin
               pd = mod_ten(p_rd.quo);
               cnt_in[pd] = cnt_ff[pd] + 1'b1;
            end
            if (i_ff == n_ff) begin
               state_in = ST_PREFIX;
               i_in = n_ff;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         ST_PREFIX: begin
            for (int k = 1; k < RADIX; k++) cnt_in[k] = cnt_in[k-1] + cnt_ff[k];
            state_in = ST_PLACE_RD;
         end
         ST_PLACE_RD: begin
            p_ra = IDX_W'(i_ff - 1'b1);
            state_in = ST_PLACE_WR;
         end
         ST_PLACE_WR: begin
            pd = mod_ten(p_rd.quo);
            cnt_in[pd] = cnt_ff[pd] - 1'b1;
            s_we = 1'b1;
            s_wa = IDX_W'(cnt_ff[pd] - 1'b1);
            i_in = i_ff - 1'b1;
            if (i_ff == CNT_W'(1)) begin
               i_in = '0;
               state_in = ST_COPY_RD;
            end else begin
               state_in = ST_PLACE_RD;
            end
         end
         ST_COPY_RD: begin
            s_ra = i_ff[IDX_W-1:0];
            state_in = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            p_we = 1'b1;
            p_wa = i_ff[IDX_W-1:0];
            p_wd.value = s_rd.value;
            p_wd.quo = div_ten(s_rd.quo);
            i_in = i_ff + 1'b1;
            if (i_in == n_ff) state_in = ST_NEXT;
            else state_in = ST_COPY_RD;
         end
         ST_NEXT: begin
            div_in = div_ten(div_ff);
            state_in = ST_CLEAR;
         end
         ST_OUT_RD: begin
            if (!out_valid_ff || rsp_ready) begin
               p_ra = i_ff[IDX_W-1:0];
               state_in = ST_OUT_WR;
            end
         end
         ST_OUT_WR: begin
            out_valid_in = 1'b1;
            out_in.sorted_value = p_rd.value;
            out_in.last_out = (i_ff + 1'b1 == n_ff);
            out_in.overflow = ovf_ff;
            i_in = i_ff + 1'b1;
            if (i_ff + 1'b1 == n_ff) begin
               n_in = '0;
               max_in = '0;
               ovf_in = 1'b0;
               i_in = '0;
               state_in = ST_LOAD;
            end else begin
               state_in = ST_OUT_RD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         n_ff <= '0;
         i_ff <= '0;
         max_ff <= '0;
         ovf_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < RADIX; k++) cnt_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         n_ff <= n_in;
         i_ff <= i_in;
         max_ff <= max_in;
         ovf_ff <= ovf_in;
         out_valid_ff <= out_valid_in;
         cnt_ff <= cnt_in;
      end
      div_ff <= div_in;
      out_ff <= out_in;
   end

   `DLRS_ASSERT(a_out_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid,
      "result dropped while stalled")
   `DLRS_ASSERT(a_n_bound, clock, reset, n_ff <= CNT_W'(MAX_ITEMS), "item count overran")
   `DLRS_ASSERT(a_load_only, clock, reset, cmd_ready |-> state_ff == ST_LOAD,
      "command taken while sorting")
endmodule

// ----- rtl/decimal_lsd_radix_sorter.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// decimal_lsd_radix_sorter
// Collects a set of values and emits them in ascending order after decimal
// LSD counting-sort passes.
//
// Channel  Ports                        Word
// req      req_valid/ready/data         one value, last_in closes the set
// rsp      rsp_valid/ready/data         one sorted value, last_out, overflow
//
// Loading takes in the words as they arrive. Each digit pass counts, sums,
// places and copies back over the value buffer RAM ports; there are up to
// ten passes, set by the largest value. Output reads and issues one word at
// a time. Reset is synchronous. Either side may stall; a two-entry queue
// decouples input from the engine.
// ---------------------------------------------------------------------------
module decimal_lsd_radix_sorter import dlrs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   logic    cmd_valid, cmd_ready;
   cmd_type cmd_data;

   dlrs_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_data(req_data), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
      .cmd_data(cmd_data));

   dlrs_back u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
      .cmd_data(cmd_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_data(rsp_data));
endmodule

// ----- bench/decimal_lsd_radix_sorter_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// decimal_lsd_radix_sorter_checker
// Watches both channels of the sorter, builds the expected ascending output
// of each set as its words arrive, and compares every output word in order.
// ---------------------------------------------------------------------------
module decimal_lsd_radix_sorter_checker import dlrs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count,
   output int      words_checked
);
   logic [VAL_W-1:0] set_values[$];
   logic             set_dropped;
   rsp_type          sorted_expect[$];

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
   endtask

   // Digit-by-digit stable pass; the order it produces is the ascending order.
   task automatic sort_and_queue();
      logic [VAL_W-1:0] work[$];
      logic [VAL_W-1:0] bucket[10][$];
      logic [VAL_W-1:0] top;
      longint unsigned  place;
      int               d;
      rsp_type          r;
      work = set_values;
      top = 0;
      foreach (work[i]) if (work[i] > top) top = work[i];
      for (place = 1; top / place > 0; place *= 10) begin
         for (int k = 0; k < 10; k++) bucket[k].delete();
         foreach (work[i]) begin
            d = int'((work[i] / place) % 10);
            bucket[d].push_back(work[i]);
         end
         work.delete();
         for (int k = 0; k < 10; k++) foreach (bucket[k][j]) work.push_back(bucket[k][j]);
      end
      foreach (work[i]) begin
         r.sorted_value = work[i];
         r.last_out = (i == work.size() - 1);
         r.overflow = set_dropped;
         sorted_expect.push_back(r);
      end
      set_values.delete();
      set_dropped = 0;
   endtask

   assign pending_count = sorted_expect.size();

   initial begin
      fail_count = 0;
      words_checked = 0;
      set_dropped = 0;
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (set_values.size() < MAX_ITEMS) set_values.push_back(req_data.value);
            else set_dropped = 1;
            if (req_data.last_in) sort_and_queue();
         end
         if (rsp_valid && rsp_ready) begin
            words_checked++;
            if (sorted_expect.size() == 0) begin
               report_mismatch($sformatf("unexpected word %0d", rsp_data.sorted_value));
            end else begin
               e = sorted_expect.pop_front();
               if (rsp_data.sorted_value !== e.sorted_value)
                  report_mismatch($sformatf("sorted_value %0d, expected %0d",
                     rsp_data.sorted_value, e.sorted_value));
               if (rsp_data.last_out !== e.last_out)
                  report_mismatch($sformatf("last_out %0b, expected %0b",
                     rsp_data.last_out, e.last_out));
               if (rsp_data.overflow !== e.overflow)
                  report_mismatch($sformatf("overflow %0b, expected %0b",
                     rsp_data.overflow, e.overflow));
            end
         end
      end
   end
endmodule

// ----- bench/decimal_lsd_radix_sorter_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// decimal_lsd_radix_sorter_tb
// Drives directed and random sets into the sorter under varied idling on
// both channels, and gives the verdict from the checker's failure count.
// ---------------------------------------------------------------------------
module decimal_lsd_radix_sorter_tb;
   import dlrs_pkg::*;

   localparam int STALL_LIMIT = 200000;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_data;
   int      fail_count, pending_count, words_checked;
   int      send_idle_pct = 0, recv_stall_pct = 0;
   int      words_sent = 0, sets_sent = 0, quiet_cycles = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   decimal_lsd_radix_sorter i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

   decimal_lsd_radix_sorter_checker i_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .fail_count, .pending_count, .words_checked
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!reset && ((req_valid && req_ready) || (rsp_valid && rsp_ready))) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no word moved in %0d cycles", STALL_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_word(input logic [VAL_W-1:0] v, input logic closes);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= '{value: v, last_in: closes};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      if (closes) sets_sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   function automatic logic [VAL_W-1:0] random_value();
      case ($urandom_range(3))
         0: return VAL_W'($urandom_range(9));
         1: return VAL_W'($urandom_range(999));
         2: return VAL_W'($urandom_range(999999));
         default: return VAL_W'($urandom);
      endcase
   endfunction

   task automatic send_set(input int n);
      for (int i = 0; i < n; i++) send_word(random_value(), i == n - 1);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_word(0, 1);
      send_word('1, 1);
      send_word(5, 0); send_word(5, 0); send_word(0, 0); send_word('1, 0);
      send_word(1000000000, 0); send_word(9, 0); send_word(10, 1);
      for (int i = 0; i < 70; i++) send_word(random_value(), i == 69);
      drain();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = (p == 1 || p == 3) ? (p == 3 ? 16 : 82) : 0;
         recv_stall_pct = (p == 2 || p == 3) ? (p == 3 ? 16 : 82) : 0;
         for (int s = 0; s < 8; s++) begin
            if (s == 7) send_set(int'($urandom_range(64, 68)));
            else send_set(int'($urandom_range(1, 12)));
         end
         drain();
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();
      repeat (200) @(posedge clock);
      $display("Sent %0d words in %0d sets; checked %0d sorted words.",
         words_sent, sets_sent, words_checked);
      $display("Phases covered free flow, idle sender, stalled receiver and both.");
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
